// ===== design/partition_fit_allocator_top_macros.svh =====
// assertion macros shared by the checker
// no dependencies
`ifndef PARTITION_FIT_ALLOCATOR_TOP_MACROS_SVH
`define PARTITION_FIT_ALLOCATOR_TOP_MACROS_SVH
`define PFA_ASSERT_IMPL(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);
`define PFA_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);
`endif

// ===== design/pfa_pkg.sv =====
// types and constants for the partition fit allocator
// no dependencies
package pfa_pkg;
  localparam int TableDepth = 16;
  localparam int AddrWidth = 20;
  localparam int LenWidth = 21;
  localparam int IdWidth = 16;
  localparam int ThrWidth = 20;
  localparam int IdxWidth = $clog2(TableDepth);
  localparam int CfgWidth = 20;
  localparam int CfgIdxWidth = 1;

  localparam logic [CfgIdxWidth-1:0] CfgFitPolicy = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgThreshold = 1'd1;
  localparam logic [ThrWidth-1:0] ThresholdReset = 20'd5;

  localparam logic OpAdd = 1'b0;
  localparam logic OpAlloc = 1'b1;

  typedef enum logic [1:0] {
    FitFirst = 2'd0,
    FitBest = 2'd1,
    FitWorst = 2'd2,
    FitNext = 2'd3
  } fit_t;

  typedef enum logic [1:0] {
    StatOk = 2'd0,
    StatNoFit = 2'd1,
    StatEmpty = 2'd2,
    StatFull = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StDone
  } state_t;

  typedef struct packed {
    logic opcode;
    logic [IdWidth-1:0] process_id;
    logic [AddrWidth-1:0] block_start;
    logic [LenWidth-1:0] request_size;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [IdWidth-1:0] granted_id;
    logic [AddrWidth-1:0] granted_address;
    logic [LenWidth-1:0] granted_size;
  } result_t;

  typedef struct packed {
    logic valid;
    logic [AddrWidth-1:0] address;
    logic [LenWidth-1:0] length;
  } slot_t;
endpackage

// ===== design/pfa_compare.sv =====
// shared compare unit: decides whether a candidate slot beats the current pick
// depends on pfa_pkg
module pfa_compare (
  input  pfa_pkg::fit_t                     policy,
  input  logic [pfa_pkg::AddrWidth-1:0]     roving,
  input  logic [pfa_pkg::LenWidth-1:0]      request,
  input  pfa_pkg::slot_t                    cand,
  input  logic                              have_pick,
  input  pfa_pkg::slot_t                    pick,
  output logic                              take
);
  import pfa_pkg::*;
  logic fits, prefer, ca, pa;
  always_comb begin
    fits = cand.valid && (cand.length >= request);
    ca = cand.address >= roving;
    pa = pick.address >= roving;
    prefer = cand.address < pick.address;
    unique case (policy)
      FitBest: if (cand.length != pick.length) prefer = cand.length < pick.length;
      FitWorst: if (cand.length != pick.length) prefer = cand.length > pick.length;
      FitNext: if (ca != pa) prefer = ca;
      default: ;
    endcase
    take = fits && (!have_pick || prefer);
  end
endmodule

// ===== design/partition_fit_allocator_top.sv =====
// partition fit allocator top level: slot table, scan sequencer, result register
// depends on pfa_pkg and pfa_compare
// An add goes through the update and done states; an allocate first has
// the shared compare unit visit the 16 table slots one per cycle, then the
// update state writes the chosen slot and the done state drives the result.
// busy is high from the accepting edge until the result cycle ends; done
// pulses one cycle with the result and the receiver cannot stall it.
module partition_fit_allocator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  pfa_pkg::cmd_t                     cmd,
  output logic                              busy,
  output logic                              done,
  output pfa_pkg::result_t                  result,
  input  logic                              cfg_we,
  input  logic [pfa_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [pfa_pkg::CfgWidth-1:0]      cfg_data
);
  import pfa_pkg::*;

  state_t state, state_next;
  logic [TableDepth-1:0] slot_valid;
  logic [AddrWidth-1:0] slot_address [TableDepth];
  logic [LenWidth-1:0] slot_length [TableDepth];
  logic [AddrWidth-1:0] roving;
  fit_t policy;
  logic [ThrWidth-1:0] threshold;
  cmd_t item;
  logic [IdxWidth-1:0] idx, pick_idx, free_idx;
  logic have_pick, any, have_free;
  slot_t cand, pick;
  logic take;
  logic [LenWidth-1:0] leftover;

  assign cand = '{slot_valid[idx], slot_address[idx], slot_length[idx]};
  assign pick = '{1'b1, slot_address[pick_idx], slot_length[pick_idx]};
  assign leftover = slot_length[pick_idx] - item.request_size;

  pfa_compare u_cmp (
    .policy(policy), .roving(roving), .request(item.request_size),
    .cand(cand), .have_pick(have_pick), .pick(pick), .take(take)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      StIdle: if (start) state_next = (cmd.opcode == OpAlloc) ? StScan : StUpdate;
      StScan: if (idx == IdxWidth'(TableDepth - 1)) state_next = StUpdate;
      StUpdate: state_next = StDone;
      StDone: state_next = StIdle;
      default: state_next = StIdle;
    endcase
  end

  assign busy = (state != StIdle);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      slot_valid <= '0;
      roving <= '0;
      policy <= FitFirst;
      threshold <= ThresholdReset;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == StUpdate);
      if (cfg_we) begin
        unique case (cfg_index)
          CfgFitPolicy: policy <= fit_t'(cfg_data[1:0]);
          CfgThreshold: threshold <= cfg_data[ThrWidth-1:0];
          default: ;
        endcase
      end
      if (state == StUpdate) begin
        if (item.opcode == OpAdd) begin
          if (have_free) slot_valid[free_idx] <= 1'b1;
        end else if (any && have_pick) begin
          if (leftover <= LenWidth'(threshold)) slot_valid[pick_idx] <= 1'b0;
          if (policy == FitNext) begin
            roving <= slot_address[pick_idx] + ((leftover > LenWidth'(threshold))
              ? item.request_size[AddrWidth-1:0] : slot_length[pick_idx][AddrWidth-1:0]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == StIdle && start) begin
      item <= cmd;
      idx <= '0;
      have_pick <= 1'b0;
      any <= 1'b0;
      pick_idx <= '0;
    end
    if (state == StScan) begin
      idx <= idx + IdxWidth'(1);
      if (cand.valid) any <= 1'b1;
      if (take) begin
        have_pick <= 1'b1;
        pick_idx <= idx;
      end
    end
    if (state == StUpdate) begin
      result.granted_id <= item.process_id;
      result.granted_address <= '0;
      result.granted_size <= '0;
      if (item.opcode == OpAdd) begin
        result.status <= have_free ? StatOk : StatFull;
        if (have_free) begin
          slot_address[free_idx] <= item.block_start;
          slot_length[free_idx] <= item.request_size;
        end
      end else if (!any) begin
        result.status <= StatEmpty;
      end else if (!have_pick) begin
        result.status <= StatNoFit;
      end else begin
        result.status <= StatOk;
        result.granted_address <= slot_address[pick_idx];
        if (leftover > LenWidth'(threshold)) begin
          result.granted_size <= item.request_size;
          slot_address[pick_idx] <= slot_address[pick_idx]
            + item.request_size[AddrWidth-1:0];
          slot_length[pick_idx] <= leftover;
        end else begin
          result.granted_size <= slot_length[pick_idx];
        end
      end
    end
  end

  // lowest empty slot, priority encoder
  always_comb begin
    have_free = 1'b0;
    free_idx = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        have_free = 1'b1;
        free_idx = IdxWidth'(i);
      end
    end
  end
endmodule

// ===== design/pfa_checker.sv =====
// port-level checker for the partition fit allocator, bound to the top level
// depends on pfa_pkg and the assertion macro header
`include "partition_fit_allocator_top_macros.svh"
module pfa_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input pfa_pkg::result_t result
);
  import pfa_pkg::*;
  `PFA_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "no busy after accept")
  `PFA_ASSERT_IMPL(a_done_busy, clk, rst, done, busy, "done outside busy")
  `PFA_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy, "done not one cycle")
  `PFA_ASSERT_IMPL(a_fail_zero, clk, rst, done && result.status != StatOk,
    result.granted_size == '0 && result.granted_address == '0, "failure carries data")
endmodule

bind partition_fit_allocator_top pfa_checker u_pfa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
